>>> hdl/avkf_pkg.sv
// shared types, constants and the micro-program of the altitude kalman filter
package avkf_pkg;

    typedef struct packed {
        logic [1:0]         kind;
        logic [19:0]        time_step;
        logic signed [31:0] accel_in;
        logic signed [31:0] altitude_in;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] altitude_out;
        logic signed [31:0] velocity_out;
        logic [1:0]         status;
    } out_word_t;

    localparam logic [1:0] KIND_INIT    = 2'd0;
    localparam logic [1:0] KIND_PREDICT = 2'd1;
    localparam logic [1:0] KIND_UPDATE  = 2'd2;

    localparam logic [1:0] ST_APPLIED   = 2'd0;
    localparam logic [1:0] ST_NOT_INIT  = 2'd1;
    localparam logic [1:0] ST_ZERO_STEP = 2'd2;
    localparam logic [1:0] ST_CLAMPED   = 2'd3;

    localparam logic CFG_SIGMA_ACCEL = 1'b0;
    localparam logic CFG_SIGMA_BARO  = 1'b1;

    localparam logic [23:0] SIGMA_RESET  = 24'd65536;
    localparam logic [19:0] STEP_LIMIT   = 20'd32768;
    localparam logic [15:0] STEP_CLAMPED = 16'd655;

    localparam logic signed [47:0] ONE_Q32  = 48'sh0001_0000_0000;
    localparam logic signed [47:0] HALF_Q32 = 48'sh0000_8000_0000;

    localparam logic signed [65:0] S32_MAX = 66'sd2147483647;
    localparam logic signed [65:0] S32_MIN = -66'sd2147483648;
    localparam logic signed [65:0] S48_MAX = 66'sd140737488355327;
    localparam logic signed [65:0] S48_MIN = -66'sd140737488355328;

    typedef enum logic [1:0] {
        UOP_MUL   = 2'd0,
        UOP_DIV   = 2'd1,
        UOP_APPLY = 2'd2
    } uop_kind_t;

    typedef enum logic [2:0] {
        AP_NONE      = 3'd0,
        AP_INIT      = 3'd1,
        AP_PREDICT   = 3'd2,
        AP_UPD_SETUP = 3'd3,
        AP_UPDATE    = 3'd4
    } apply_t;

    typedef enum logic [4:0] {
        OP_NONE = 5'd0,
        OP_D    = 5'd1,
        OP_A    = 5'd2,
        OP_DT2  = 5'd3,
        OP_DT3  = 5'd4,
        OP_DT4  = 5'd5,
        OP_AV   = 5'd6,
        OP_P0   = 5'd7,
        OP_P1   = 5'd8,
        OP_P2   = 5'd9,
        OP_P3   = 5'd10,
        OP_VEL  = 5'd11,
        OP_F01  = 5'd12,
        OP_K0   = 5'd13,
        OP_K1   = 5'd14,
        OP_Y    = 5'd15,
        OP_SA   = 5'd16,
        OP_SB   = 5'd17
    } opnd_t;

    typedef enum logic [4:0] {
        DST_NONE = 5'd0,
        DST_DT2  = 5'd1,
        DST_DT3  = 5'd2,
        DST_DT4  = 5'd3,
        DST_Q00  = 5'd4,
        DST_Q01  = 5'd5,
        DST_Q11  = 5'd6,
        DST_T0   = 5'd7,
        DST_T1   = 5'd8,
        DST_T2   = 5'd9,
        DST_T3   = 5'd10,
        DST_T4   = 5'd11,
        DST_T5   = 5'd12,
        DST_K0   = 5'd13,
        DST_K1   = 5'd14,
        DST_AV   = 5'd15,
        DST_BV   = 5'd16
    } dst_t;

    // product is rounded to nearest and shifted right by this many bits
    typedef enum logic [2:0] {
        SH_0  = 3'd0,
        SH_16 = 3'd1,
        SH_32 = 3'd2,
        SH_33 = 3'd3,
        SH_49 = 3'd4,
        SH_66 = 3'd5
    } shift_t;

    typedef struct packed {
        uop_kind_t kind;
        opnd_t     a_sel;
        opnd_t     b_sel;
        shift_t    shift;
        dst_t      dst;
        apply_t    apply;
        logic      last;
    } uop_t;

    typedef struct packed {
        logic      load;
        logic      mul_start;
        logic      div_start;
        logic      apply_en;
        opnd_t     a_sel;
        opnd_t     b_sel;
        shift_t    shift;
        dst_t      dst;
        apply_t    apply;
        logic      emit;
        logic [1:0] status;
    } cmd_t;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic ready_flag;
        logic s_pos;
        logic out_free;
    } stat_t;

    localparam int PC_W = 5;
    localparam logic [PC_W-1:0] PC_INIT    = 5'd0;
    localparam logic [PC_W-1:0] PC_PREDICT = 5'd3;
    localparam logic [PC_W-1:0] PC_UPDATE  = 5'd16;

    function automatic uop_t mk_mul(opnd_t a, opnd_t b, shift_t sh, dst_t d);
        uop_t u;
        u.kind  = UOP_MUL;
        u.a_sel = a;
        u.b_sel = b;
        u.shift = sh;
        u.dst   = d;
        u.apply = AP_NONE;
        u.last  = 1'b0;
        return u;
    endfunction

    function automatic uop_t mk_div(opnd_t a, dst_t d);
        uop_t u;
        u.kind  = UOP_DIV;
        u.a_sel = a;
        u.b_sel = OP_NONE;
        u.shift = SH_0;
        u.dst   = d;
        u.apply = AP_NONE;
        u.last  = 1'b0;
        return u;
    endfunction

    function automatic uop_t mk_apply(apply_t ap, logic last);
        uop_t u;
        u.kind  = UOP_APPLY;
        u.a_sel = OP_NONE;
        u.b_sel = OP_NONE;
        u.shift = SH_0;
        u.dst   = DST_NONE;
        u.apply = ap;
        u.last  = last;
        return u;
    endfunction

    function automatic uop_t uop_at(logic [PC_W-1:0] pc);
        uop_t u;
        unique case (pc)
            // init
            5'd0:  u = mk_mul(OP_SA, OP_SA, SH_0, DST_AV);
            5'd1:  u = mk_mul(OP_SB, OP_SB, SH_0, DST_BV);
            5'd2:  u = mk_apply(AP_INIT, 1'b1);
            // predict
            5'd3:  u = mk_mul(OP_D, OP_D, SH_0, DST_DT2);
            5'd4:  u = mk_mul(OP_DT2, OP_D, SH_0, DST_DT3);
            5'd5:  u = mk_mul(OP_DT2, OP_DT2, SH_0, DST_DT4);
            5'd6:  u = mk_mul(OP_AV, OP_DT4, SH_66, DST_Q00);
            5'd7:  u = mk_mul(OP_AV, OP_DT3, SH_49, DST_Q01);
            5'd8:  u = mk_mul(OP_AV, OP_DT2, SH_32, DST_Q11);
            5'd9:  u = mk_mul(OP_P2, OP_D, SH_16, DST_T0);
            5'd10: u = mk_mul(OP_P3, OP_D, SH_16, DST_T1);
            5'd11: u = mk_mul(OP_VEL, OP_D, SH_16, DST_T2);
            5'd12: u = mk_mul(OP_A, OP_DT2, SH_33, DST_T3);
            5'd13: u = mk_mul(OP_A, OP_D, SH_16, DST_T4);
            5'd14: u = mk_mul(OP_F01, OP_D, SH_16, DST_T5);
            5'd15: u = mk_apply(AP_PREDICT, 1'b1);
            // update
            5'd16: u = mk_apply(AP_UPD_SETUP, 1'b0);
            5'd17: u = mk_div(OP_P0, DST_K0);
            5'd18: u = mk_div(OP_P2, DST_K1);
            5'd19: u = mk_mul(OP_K0, OP_Y, SH_32, DST_T0);
            5'd20: u = mk_mul(OP_K1, OP_Y, SH_32, DST_T1);
            5'd21: u = mk_mul(OP_K0, OP_P0, SH_32, DST_T2);
            5'd22: u = mk_mul(OP_K0, OP_P1, SH_32, DST_T3);
            5'd23: u = mk_mul(OP_K1, OP_P0, SH_32, DST_T4);
            5'd24: u = mk_mul(OP_K1, OP_P1, SH_32, DST_T5);
            5'd25: u = mk_apply(AP_UPDATE, 1'b1);
            default: u = mk_apply(AP_NONE, 1'b1);
        endcase
        return u;
    endfunction

    function automatic logic signed [31:0] sat32(logic signed [65:0] x);
        if (x > S32_MAX)
            return 32'sh7FFF_FFFF;
        else if (x < S32_MIN)
            return 32'sh8000_0000;
        else
            return x[31:0];
    endfunction

    function automatic logic signed [47:0] sat48(logic signed [65:0] x);
        if (x > S48_MAX)
            return 48'sh7FFF_FFFF_FFFF;
        else if (x < S48_MIN)
            return 48'sh8000_0000_0000;
        else
            return x[47:0];
    endfunction

endpackage

>>> hdl/avkf_mul.sv
// shared multiplier: 64x64 magnitude product over four 32x32 steps, then round and cap
module avkf_mul
    import avkf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [63:0] a,
    input  logic signed [63:0] b,
    input  shift_t             shift,
    output logic               done,
    output logic signed [63:0] result
);

    localparam logic [2:0] MUL_STEPS = 3'd4;
    localparam logic [128:0] CAP = 129'd1 << 62;

    logic [63:0]  ma_reg, mb_reg;
    logic         neg_reg;
    shift_t       sh_reg;
    logic [127:0] acc_reg;
    logic [2:0]   cnt_reg;
    logic         busy_reg, done_reg;
    logic signed [63:0] res_reg;

    logic [31:0]  mx, my;
    logic [63:0]  part;
    logic [127:0] part_sh;
    logic [128:0] sum, r;
    logic [62:0]  mag_r;
    logic signed [63:0] res_next;

    always_comb
    begin
        mx   = cnt_reg[1] ? ma_reg[63:32] : ma_reg[31:0];
        my   = cnt_reg[0] ? mb_reg[63:32] : mb_reg[31:0];
        part = mx * my;
        case (cnt_reg)
            3'd0:    part_sh = 128'(part);
            3'd3:    part_sh = 128'(part) << 64;
            default: part_sh = 128'(part) << 32;
        endcase
    end

    // round to nearest, ties away from zero on the magnitude
    always_comb
    begin
        sum = '0;
        r   = {1'b0, acc_reg};
        case (sh_reg)
            SH_16:
            begin
                sum = {1'b0, acc_reg} + (129'd1 << 15);
                r   = sum >> 16;
            end
            SH_32:
            begin
                sum = {1'b0, acc_reg} + (129'd1 << 31);
                r   = sum >> 32;
            end
            SH_33:
            begin
                sum = {1'b0, acc_reg} + (129'd1 << 32);
                r   = sum >> 33;
            end
            SH_49:
            begin
                sum = {1'b0, acc_reg} + (129'd1 << 48);
                r   = sum >> 49;
            end
            SH_66:
            begin
                sum = {1'b0, acc_reg} + (129'd1 << 65);
                r   = sum >> 66;
            end
            default: r = {1'b0, acc_reg};
        endcase
        mag_r    = (r > CAP) ? CAP[62:0] : r[62:0];
        res_next = neg_reg ? -$signed(64'(mag_r)) : $signed(64'(mag_r));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == MUL_STEPS)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ma_reg  <= a[63] ? 64'(-a) : 64'(a);
            mb_reg  <= b[63] ? 64'(-b) : 64'(b);
            neg_reg <= a[63] ^ b[63];
            sh_reg  <= shift;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == MUL_STEPS)
                res_reg <= res_next;
            else
                acc_reg <= acc_reg + part_sh;
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

>>> hdl/avkf_div.sv
// restoring divider for the kalman gain: (num << 32) / den, one quotient bit per cycle
module avkf_div
    import avkf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [47:0] num,
    input  logic [48:0]        den,
    output logic               done,
    output logic signed [63:0] result
);

    localparam logic [6:0] DIV_STEPS = 7'd80;
    localparam logic [79:0] CAP = 80'd1 << 62;

    logic [79:0] dvd_reg;
    logic [48:0] rem_reg, den_reg;
    logic        neg_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg, done_reg;
    logic signed [63:0] res_reg;

    logic [49:0] trial;
    logic        ge;
    logic [49:0] diff;
    logic [62:0] mag_q;

    always_comb
    begin
        trial = {rem_reg, dvd_reg[79]};
        ge    = trial >= {1'b0, den_reg};
        diff  = trial - {1'b0, den_reg};
        mag_q = (dvd_reg > CAP) ? CAP[62:0] : dvd_reg[62:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == DIV_STEPS)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 7'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= {(num[47] ? 48'(-num) : 48'(num)), 32'd0};
            rem_reg <= '0;
            den_reg <= den;
            neg_reg <= num[47];
        end
        else if (busy_reg)
        begin
            if (cnt_reg == DIV_STEPS)
            begin
                res_reg <= neg_reg ? -$signed(64'(mag_q)) : $signed(64'(mag_q));
            end
            else
            begin
                rem_reg <= ge ? diff[48:0] : trial[48:0];
                dvd_reg <= {dvd_reg[78:0], ge};
            end
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

>>> hdl/avkf_dp.sv
// datapath: filter state, operand selection, shared multiplier and divider, output register
module avkf_dp
    import avkf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output stat_t       stat,
    input  in_word_t    in_data,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [23:0] cfg_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_word_t   out_data
);

    logic [23:0]        sa_reg, sb_reg;
    logic signed [31:0] alt_reg, vel_reg;
    logic signed [47:0] p0_reg, p1_reg, p2_reg, p3_reg;
    logic [47:0]        av_reg, bv_reg;
    logic               ready_reg;

    logic [15:0]        d_reg;
    logic signed [31:0] a_reg, z_reg;
    logic [30:0]        dt2_reg;
    logic [45:0]        dt3_reg;
    logic [60:0]        dt4_reg;
    logic [47:0]        q00_reg, q01_reg, q11_reg;
    logic signed [63:0] t0_reg, t1_reg, t2_reg, t3_reg, t4_reg, t5_reg;
    logic signed [63:0] k0_reg, k1_reg;
    logic signed [49:0] s_reg;
    logic signed [32:0] y_reg;

    logic               out_valid_reg;
    out_word_t          out_word_reg;

    logic signed [63:0] opa, opb;
    logic signed [47:0] f00, f01;
    logic               mul_done, div_done;
    logic signed [63:0] mul_res, div_res;

    assign f00 = sat48(66'(p0_reg) + 66'(t0_reg));
    assign f01 = sat48(66'(p1_reg) + 66'(t1_reg));

    always_comb
    begin
        case (cmd.a_sel)
            OP_D:    opa = 64'(d_reg);
            OP_A:    opa = 64'(a_reg);
            OP_DT2:  opa = 64'(dt2_reg);
            OP_DT3:  opa = 64'(dt3_reg);
            OP_DT4:  opa = 64'(dt4_reg);
            OP_AV:   opa = 64'(av_reg);
            OP_P0:   opa = 64'(p0_reg);
            OP_P1:   opa = 64'(p1_reg);
            OP_P2:   opa = 64'(p2_reg);
            OP_P3:   opa = 64'(p3_reg);
            OP_VEL:  opa = 64'(vel_reg);
            OP_F01:  opa = 64'(f01);
            OP_K0:   opa = k0_reg;
            OP_K1:   opa = k1_reg;
            OP_Y:    opa = 64'(y_reg);
            OP_SA:   opa = 64'(sa_reg);
            OP_SB:   opa = 64'(sb_reg);
            default: opa = '0;
        endcase
    end

    always_comb
    begin
        case (cmd.b_sel)
            OP_D:    opb = 64'(d_reg);
            OP_A:    opb = 64'(a_reg);
            OP_DT2:  opb = 64'(dt2_reg);
            OP_DT3:  opb = 64'(dt3_reg);
            OP_DT4:  opb = 64'(dt4_reg);
            OP_AV:   opb = 64'(av_reg);
            OP_P0:   opb = 64'(p0_reg);
            OP_P1:   opb = 64'(p1_reg);
            OP_P2:   opb = 64'(p2_reg);
            OP_P3:   opb = 64'(p3_reg);
            OP_VEL:  opb = 64'(vel_reg);
            OP_F01:  opb = 64'(f01);
            OP_K0:   opb = k0_reg;
            OP_K1:   opb = k1_reg;
            OP_Y:    opb = 64'(y_reg);
            OP_SA:   opb = 64'(sa_reg);
            OP_SB:   opb = 64'(sb_reg);
            default: opb = '0;
        endcase
    end

    avkf_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.mul_start),
        .a      (opa),
        .b      (opb),
        .shift  (cmd.shift),
        .done   (mul_done),
        .result (mul_res)
    );

    avkf_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.div_start),
        .num    (opa[47:0]),
        .den    (s_reg[48:0]),
        .done   (div_done),
        .result (div_res)
    );

    // control and observable state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sa_reg        <= SIGMA_RESET;
            sb_reg        <= SIGMA_RESET;
            alt_reg       <= '0;
            vel_reg       <= '0;
            ready_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_SIGMA_ACCEL: sa_reg <= cfg_data;
                    CFG_SIGMA_BARO:  sb_reg <= cfg_data;
                    default:         sa_reg <= sa_reg;
                endcase
            end
            if (cmd.apply_en)
            begin
                unique case (cmd.apply)
                    AP_INIT:
                    begin
                        alt_reg   <= z_reg;
                        vel_reg   <= '0;
                        ready_reg <= 1'b1;
                    end
                    AP_PREDICT:
                    begin
                        alt_reg <= sat32(66'(alt_reg) + 66'(t2_reg) + 66'(t3_reg));
                        vel_reg <= sat32(66'(vel_reg) + 66'(t4_reg));
                    end
                    AP_UPDATE:
                    begin
                        alt_reg <= sat32(66'(alt_reg) + 66'(t0_reg));
                        vel_reg <= sat32(66'(vel_reg) + 66'(t1_reg));
                    end
                    default: ready_reg <= ready_reg;
                endcase
            end
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            d_reg <= (in_data.time_step > STEP_LIMIT) ? STEP_CLAMPED : in_data.time_step[15:0];
            a_reg <= in_data.accel_in;
            z_reg <= in_data.altitude_in;
        end
        if (mul_done)
        begin
            case (cmd.dst)
                DST_DT2: dt2_reg <= mul_res[30:0];
                DST_DT3: dt3_reg <= mul_res[45:0];
                DST_DT4: dt4_reg <= mul_res[60:0];
                DST_Q00: q00_reg <= mul_res[47:0];
                DST_Q01: q01_reg <= mul_res[47:0];
                DST_Q11: q11_reg <= mul_res[47:0];
                DST_T0:  t0_reg  <= mul_res;
                DST_T1:  t1_reg  <= mul_res;
                DST_T2:  t2_reg  <= mul_res;
                DST_T3:  t3_reg  <= mul_res;
                DST_T4:  t4_reg  <= mul_res;
                DST_T5:  t5_reg  <= mul_res;
                DST_AV:  av_reg  <= mul_res[47:0];
                DST_BV:  bv_reg  <= mul_res[47:0];
                default: t0_reg  <= t0_reg;
            endcase
        end
        if (div_done)
        begin
            if (cmd.dst == DST_K1)
                k1_reg <= div_res;
            else
                k0_reg <= div_res;
        end
        if (cmd.apply_en)
        begin
            unique case (cmd.apply)
                AP_INIT:
                begin
                    p0_reg <= ONE_Q32;
                    p1_reg <= '0;
                    p2_reg <= '0;
                    p3_reg <= HALF_Q32;
                end
                AP_PREDICT:
                begin
                    p0_reg <= sat48(66'(f00) + 66'(t5_reg) + 66'(q00_reg));
                    p1_reg <= sat48(66'(f01) + 66'(q01_reg));
                    p2_reg <= sat48(66'(p2_reg) + 66'(t1_reg) + 66'(q01_reg));
                    p3_reg <= sat48(66'(p3_reg) + 66'(q11_reg));
                end
                AP_UPD_SETUP:
                begin
                    s_reg <= 50'(p0_reg) + $signed(50'(bv_reg));
                    y_reg <= 33'(z_reg) - 33'(alt_reg);
                end
                AP_UPDATE:
                begin
                    p0_reg <= sat48(66'(p0_reg) - 66'(t2_reg));
                    p1_reg <= sat48(66'(p1_reg) - 66'(t3_reg));
                    p2_reg <= sat48(66'(p2_reg) - 66'(t4_reg));
                    p3_reg <= sat48(66'(p3_reg) - 66'(t5_reg));
                end
                default: s_reg <= s_reg;
            endcase
        end
        if (cmd.emit)
        begin
            out_word_reg.altitude_out <= alt_reg;
            out_word_reg.velocity_out <= vel_reg;
            out_word_reg.status       <= cmd.status;
        end
    end

    always_comb
    begin
        stat.mul_done   = mul_done;
        stat.div_done   = div_done;
        stat.ready_flag = ready_reg;
        stat.s_pos      = !s_reg[49] && (s_reg != '0);
        stat.out_free   = !out_valid_reg || !out_stall;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;

endmodule

>>> hdl/avkf_ctrl.sv
// controller: decodes the word kind and steps the micro-program through the datapath
module avkf_ctrl
    import avkf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  in_kind,
    input  logic [19:0] in_step,
    output cmd_t        cmd,
    input  stat_t       stat
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_ISSUE  = 4'b0010,
        S_WAIT   = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t          state_reg, state_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    logic [1:0]      status_reg, status_next;
    uop_t            uop;
    logic            op_done;

    always_comb
    begin
        uop         = uop_at(pc_reg);
        state_next  = state_reg;
        pc_next     = pc_reg;
        status_next = status_reg;
        op_done     = 1'b0;

        cmd.load      = 1'b0;
        cmd.mul_start = 1'b0;
        cmd.div_start = 1'b0;
        cmd.apply_en  = 1'b0;
        cmd.a_sel     = uop.a_sel;
        cmd.b_sel     = uop.b_sel;
        cmd.shift     = uop.shift;
        cmd.dst       = uop.dst;
        cmd.apply     = uop.apply;
        cmd.emit      = 1'b0;
        cmd.status    = status_reg;

        in_stall = (state_reg != S_IDLE);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load    = 1'b1;
                    status_next = ST_APPLIED;
                    state_next  = S_FINISH;
                    unique case (in_kind)
                        KIND_INIT:
                        begin
                            pc_next    = PC_INIT;
                            state_next = S_ISSUE;
                        end
                        KIND_PREDICT:
                        begin
                            if (!stat.ready_flag)
                                status_next = ST_NOT_INIT;
                            else if (in_step == '0)
                                status_next = ST_ZERO_STEP;
                            else
                            begin
                                if (in_step > STEP_LIMIT)
                                    status_next = ST_CLAMPED;
                                pc_next    = PC_PREDICT;
                                state_next = S_ISSUE;
                            end
                        end
                        KIND_UPDATE:
                        begin
                            if (!stat.ready_flag)
                                status_next = ST_NOT_INIT;
                            else
                            begin
                                pc_next    = PC_UPDATE;
                                state_next = S_ISSUE;
                            end
                        end
                        default: state_next = S_FINISH;
                    endcase
                end
            end
            S_ISSUE:
            begin
                case (uop.kind)
                    UOP_MUL:   cmd.mul_start = 1'b1;
                    UOP_DIV:   cmd.div_start = 1'b1;
                    default:   cmd.apply_en  = 1'b1;
                endcase
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                case (uop.kind)
                    UOP_MUL: op_done = stat.mul_done;
                    UOP_DIV: op_done = stat.div_done;
                    default: op_done = 1'b1;
                endcase
                if (op_done)
                begin
                    // a non-positive innovation variance leaves the state untouched
                    if (uop.last || (uop.kind == UOP_APPLY && uop.apply == AP_UPD_SETUP
                                     && !stat.s_pos))
                        state_next = S_FINISH;
                    else
                    begin
                        pc_next    = pc_reg + 5'd1;
                        state_next = S_ISSUE;
                    end
                end
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            pc_reg     <= '0;
            status_reg <= ST_APPLIED;
        end
        else
        begin
            state_reg  <= state_next;
            pc_reg     <= pc_next;
            status_reg <= status_next;
        end
    end

endmodule

>>> hdl/altitude_velocity_kalman_filter.sv
// top level of the two-state altitude and vertical velocity kalman filter
//
// in channel: one word per step (kind, time_step, accel_in, altitude_in), taken on
// in_valid high and in_stall low. out channel: one word per input word carrying
// the estimates after the step and a status code, taken on out_valid high and
// out_stall low. cfg channel: cfg_ready is always high; index 0 writes sigma_accel,
// index 1 writes sigma_baro; write only while no word is in flight.
// one word is worked on at a time. every product goes through one shared 32x32
// multiplier in four partial steps, and each gain comes from the bit-serial divider.
// the output register holds the finished word, so the next word is accepted while
// it waits; a stalled receiver holds the block only when the next result is ready.
// reset clears the estimates to zero, marks the filter not initialized and sets
// both sigma registers to 1.0.
module altitude_velocity_kalman_filter
    import avkf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_word_t    in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_word_t   out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [23:0] cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;

    avkf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_kind  (in_data.kind),
        .in_step  (in_data.time_step),
        .cmd      (cmd),
        .stat     (stat)
    );

    avkf_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (in_data),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // a unit finishing means a word is in flight, so no new word may enter
    assert property (@(posedge clk) disable iff (!rst_n)
        (stat.mul_done || stat.div_done) |-> in_stall)
        else $error("unit finished while input was open");

    // an emitted word is presented in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> out_valid)
        else $error("emitted word not presented");

    // a new output word appears only after an emit
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.emit))
        else $error("output valid without emit");

    // the two arithmetic units never start together
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.mul_start && cmd.div_start))
        else $error("multiplier and divider started together");

endmodule
